### rtl/twbh_pkg.sv
// ----------------------------------------------------------------------------
// twbh_pkg
// Shared widths, request codes and bus types of the time weighted histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package twbh_pkg;

  // number of bins
  localparam int BUCKETS = 128;
  localparam int BIN_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int Q_W     = BIN_W + 1;

  // field widths
  localparam int REQ_W  = 2;
  localparam int POS_W  = 14;
  localparam int BPM_W  = 9;
  localparam int DT_W   = 16;
  localparam int SEL_W  = 7;
  localparam int IDX_W  = 7;
  localparam int AVG_W  = 17;
  localparam int CNT_W  = 8;
  localparam int W_W    = BPM_W + DT_W;

  // accumulator widths
  localparam int BIN_WSUM_W = 48;
  localparam int BIN_DUR_W  = 40;
  localparam int TOT_WSUM_W = 56;
  localparam int TOT_DUR_W  = 48;

  // request codes
  localparam logic [REQ_W-1:0] REQ_RECORD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // full scale position and bin mapping by reciprocal multiply
  localparam logic [POS_W-1:0] FULL_POS = 14'd10000;
  localparam int X_W       = 24;
  localparam int RECIP_SH  = 38;
  localparam int RECIP_W   = 25;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SH) / 64'd10000);

  // averages are in 1/256 units and limited to the largest rate
  localparam int AVG_FRAC = 8;
  localparam int RATE_MAX = (1 << BPM_W) - 1;
  localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(RATE_MAX * (1 << AVG_FRAC));

  // divider widths
  localparam int DIV_NUM_W = TOT_WSUM_W;
  localparam int DIV_DEN_W = TOT_DUR_W;
  localparam int DIV_LIM_W = DIV_DEN_W + BPM_W;
  localparam int DIV_CNT_W = $clog2(AVG_W);

  // one bin of the store
  typedef struct packed {
    logic [BIN_WSUM_W-1:0] wsum;
    logic [BIN_DUR_W-1:0]  dur;
  } bin_entry_t;

  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] addr;
    bin_entry_t       data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [BIN_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/twbh_if.sv
// ----------------------------------------------------------------------------
// twbh_if
// Valid/ready channels for requests and results of the histogram.
// ----------------------------------------------------------------------------
`default_nettype none

interface twbh_req_if import twbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] percent_hundredths;
  logic [BPM_W-1:0] bpm;
  logic [DT_W-1:0]  dt_ms;
  logic [SEL_W-1:0] bucket_sel;

  modport source (
    output valid, req_type, percent_hundredths, bpm, dt_ms, bucket_sel,
    input  ready
  );
  modport sink (
    input  valid, req_type, percent_hundredths, bpm, dt_ms, bucket_sel,
    output ready
  );
endinterface

interface twbh_rsp_if import twbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [IDX_W-1:0] bucket_index;
  logic [AVG_W-1:0] bucket_average;
  logic [AVG_W-1:0] overall_average;
  logic [CNT_W-1:0] covered_buckets;
  logic [BPM_W-1:0] peak_rate;
  logic [POS_W-1:0] peak_position;
  logic [POS_W-1:0] last_position;

  modport source (
    output valid, accepted, bucket_index, bucket_average, overall_average,
           covered_buckets, peak_rate, peak_position, last_position,
    input  ready
  );
  modport sink (
    input  valid, accepted, bucket_index, bucket_average, overall_average,
           covered_buckets, peak_rate, peak_position, last_position,
    output ready
  );
endinterface

`default_nettype wire

### rtl/twbh_bin_ram.sv
// ----------------------------------------------------------------------------
// twbh_bin_ram
// Per-bin sums, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module twbh_bin_ram import twbh_pkg::*; (
  input  logic       clk_i,
  input  ram_wr_t    wr_i,
  input  ram_rd_t    rd_i,
  output bin_entry_t rd_data_o
);

  bin_entry_t mem [BUCKETS];
  bin_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/twbh_div.sv
// ----------------------------------------------------------------------------
// twbh_div
// Iterative divider: floor(num*256/den), limited to the largest average.
// ----------------------------------------------------------------------------
`default_nettype none

module twbh_div import twbh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {D_IDLE, D_SCALE, D_CHECK, D_ITER} state_e;

  state_e                 state_q;
  logic [DIV_NUM_W-1:0]   num_q;
  logic [DIV_DEN_W-1:0]   den_q;
  logic [DIV_LIM_W-1:0]   lim_q;
  logic [DIV_DEN_W-1:0]   rem_q;
  logic [AVG_W-1:0]       lo_q;
  logic [AVG_W-1:0]       quot_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   done_q;

  logic [DIV_DEN_W:0]     trial;
  logic [DIV_DEN_W:0]     diff;
  logic                   ge;

  // one restoring step per cycle
  assign trial = {rem_q, lo_q[AVG_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      num_q   <= '0;
      den_q   <= '0;
      lim_q   <= '0;
      rem_q   <= '0;
      lo_q    <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            num_q   <= req_i.num;
            den_q   <= req_i.den;
            state_q <= D_SCALE;
          end
        end
        // quotient reaches the limit exactly when num >= den * max rate
        D_SCALE: begin
          lim_q   <= DIV_LIM_W'(den_q) * DIV_LIM_W'(RATE_MAX);
          state_q <= D_CHECK;
        end
        D_CHECK: begin
          cnt_q <= '0;
          priority if (den_q == '0) begin
            quot_q  <= '0;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else if (DIV_LIM_W'(num_q) >= lim_q) begin
            quot_q  <= AVG_MAX;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            // high part is below den since the quotient fits AVG_W bits
            rem_q   <= DIV_DEN_W'(num_q >> (AVG_W - AVG_FRAC));
            lo_q    <= {num_q[AVG_W-AVG_FRAC-1:0], {AVG_FRAC{1'b0}}};
            quot_q  <= '0;
            state_q <= D_ITER;
          end
        end
        D_ITER: begin
          rem_q  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
          lo_q   <= {lo_q[AVG_W-2:0], 1'b0};
          quot_q <= {quot_q[AVG_W-2:0], ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(AVG_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

### rtl/time_weighted_bucket_histogram_unit.sv
// ----------------------------------------------------------------------------
// time_weighted_bucket_histogram_unit
// Accumulates rate*duration and duration per progress bin and in total,
// and reports bin and overall averages in 1/256 rate units.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    req_type, percent_hundredths, bpm, dt_ms,
//                               bucket_sel
//  rsp_o    out  valid/ready    accepted, bucket_index, bucket_average,
//                               overall_average, covered_buckets, peak_rate,
//                               peak_position, last_position
//
//  one request at a time: a new request is taken only once the result of the
//  last one is in the output register; record and read use the shared
//  iterative divider for the bin average and then the overall one, an ignored
//  sample only for the overall average, and clear not at all.
//  bin sums live in a one-port-read memory with per-bin valid bits; reset
//  and clear drop all valid bits at once.
//  a finished result waits in the output register while the next request
//  is taken; the result stage stalls only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module time_weighted_bucket_histogram_unit import twbh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  twbh_req_if.sink  req_i,
  twbh_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EST, S_FIX, S_FETCH,
    S_BDIV, S_BWAIT, S_TDIV, S_TWAIT, S_OUT
  } state_e;

  state_e                 state_q;

  // request beat
  logic [REQ_W-1:0]       req_q;
  logic [POS_W-1:0]       pos_q;
  logic [BPM_W-1:0]       bpm_q;
  logic [DT_W-1:0]        dt_q;
  logic [SEL_W-1:0]       sel_q;
  logic [W_W-1:0]         w_q;

  // bin mapping
  logic [X_W-1:0]         x_q;
  logic [Q_W-1:0]         qest_q;
  logic [BIN_W-1:0]       bin_q;

  // histogram state
  logic [BUCKETS-1:0]     valid_q;
  logic [TOT_WSUM_W-1:0]  tot_wsum_q;
  logic [TOT_DUR_W-1:0]   tot_dur_q;
  logic [CNT_W-1:0]       cov_q;
  logic [POS_W-1:0]       end_q;
  logic [BPM_W-1:0]       peak_q;
  logic [POS_W-1:0]       peak_at_q;

  // result under construction
  bin_entry_t             ent_q;
  logic                   acc_q;
  logic [IDX_W-1:0]       idx_q;
  logic [AVG_W-1:0]       bavg_q;
  logic [AVG_W-1:0]       tavg_q;

  // output register
  logic                   out_valid_q;
  logic                   out_acc_q;
  logic [IDX_W-1:0]       out_idx_q;
  logic [AVG_W-1:0]       out_bavg_q;
  logic [AVG_W-1:0]       out_tavg_q;
  logic [CNT_W-1:0]       out_cov_q;
  logic [BPM_W-1:0]       out_peak_q;
  logic [POS_W-1:0]       out_peak_at_q;
  logic [POS_W-1:0]       out_end_q;

  ram_wr_t                ram_wr;
  ram_rd_t                ram_rd;
  bin_entry_t             ram_rdata;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   in_fire;
  logic                   out_fire;
  logic                   out_load;
  logic [BIN_W-1:0]       sel_bin;
  logic [X_W-1:0]         qprod;
  logic [X_W-1:0]         xrem;
  logic [Q_W-1:0]         qfix;
  logic [BIN_W-1:0]       bin_fix;
  logic [2*X_W+1:0]       est_prod;
  bin_entry_t             cur_ent;
  bin_entry_t             new_ent;
  logic [BIN_WSUM_W:0]    bsum_add;
  logic [BIN_DUR_W:0]     bdur_add;
  logic [TOT_WSUM_W:0]    tsum_add;
  logic [TOT_DUR_W:0]     tdur_add;
  logic                   rec_ok;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = out_valid_q && rsp_o.ready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == S_IDLE);

  assign rec_ok = (req_q == REQ_RECORD) && (bpm_q != '0) && (dt_q != '0);

  // read select past the last bin maps to the last bin
  always_comb begin
    if (32'(sel_q) >= 32'(BUCKETS)) begin
      sel_bin = BIN_W'(BUCKETS - 1);
    end else begin
      sel_bin = BIN_W'(sel_q);
    end
  end

  // bin = floor(pos*BUCKETS/10000): estimate is low by at most one
  assign est_prod = (2*X_W+2)'(x_q) * (2*X_W+2)'(RECIP);
  assign qprod    = X_W'(qest_q) * X_W'(FULL_POS);
  assign xrem     = x_q - qprod;

  always_comb begin
    qfix = (xrem >= X_W'(FULL_POS)) ? qest_q + 1'b1 : qest_q;
    if (qfix > Q_W'(BUCKETS - 1)) begin
      bin_fix = BIN_W'(BUCKETS - 1);
    end else begin
      bin_fix = BIN_W'(qfix);
    end
  end

  // never written bins read as empty
  assign cur_ent = valid_q[bin_q] ? ram_rdata : '0;

  // saturating sums
  assign bsum_add = {1'b0, cur_ent.wsum} + (BIN_WSUM_W+1)'(w_q);
  assign bdur_add = {1'b0, cur_ent.dur} + (BIN_DUR_W+1)'(dt_q);
  assign tsum_add = {1'b0, tot_wsum_q} + (TOT_WSUM_W+1)'(w_q);
  assign tdur_add = {1'b0, tot_dur_q} + (TOT_DUR_W+1)'(dt_q);

  always_comb begin
    new_ent.wsum = bsum_add[BIN_WSUM_W] ? '1 : bsum_add[BIN_WSUM_W-1:0];
    new_ent.dur  = bdur_add[BIN_DUR_W] ? '1 : bdur_add[BIN_DUR_W-1:0];
  end

  // memory ports
  always_comb begin
    ram_rd.en   = ((state_q == S_DECODE) && (req_q == REQ_READ)) ||
                  (state_q == S_FIX);
    ram_rd.addr = (state_q == S_FIX) ? bin_fix : sel_bin;
    ram_wr.en   = (state_q == S_FETCH) && (req_q == REQ_RECORD);
    ram_wr.addr = bin_q;
    ram_wr.data = new_ent;
  end

  // divider requests: bin average first, then overall
  always_comb begin
    div_req.start = (state_q == S_BDIV) || (state_q == S_TDIV);
    if (state_q == S_BDIV) begin
      div_req.num = DIV_NUM_W'(ent_q.wsum);
      div_req.den = DIV_DEN_W'(ent_q.dur);
    end else begin
      div_req.num = tot_wsum_q;
      div_req.den = tot_dur_q;
    end
  end

  twbh_bin_ram u_ram (
    .clk_i    (clk_i),
    .wr_i     (ram_wr),
    .rd_i     (ram_rd),
    .rd_data_o(ram_rdata)
  );

  twbh_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer, histogram state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      req_q         <= '0;
      pos_q         <= '0;
      bpm_q         <= '0;
      dt_q          <= '0;
      sel_q         <= '0;
      w_q           <= '0;
      x_q           <= '0;
      qest_q        <= '0;
      bin_q         <= '0;
      valid_q       <= '0;
      tot_wsum_q    <= '0;
      tot_dur_q     <= '0;
      cov_q         <= '0;
      end_q         <= '0;
      peak_q        <= '0;
      peak_at_q     <= '0;
      ent_q         <= '0;
      acc_q         <= 1'b0;
      idx_q         <= '0;
      bavg_q        <= '0;
      tavg_q        <= '0;
      out_valid_q   <= 1'b0;
      out_acc_q     <= 1'b0;
      out_idx_q     <= '0;
      out_bavg_q    <= '0;
      out_tavg_q    <= '0;
      out_cov_q     <= '0;
      out_peak_q    <= '0;
      out_peak_at_q <= '0;
      out_end_q     <= '0;
    end else begin
      if (out_fire && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        // take a request beat, clamp position, form rate*duration
        S_IDLE: begin
          if (in_fire) begin
            req_q   <= req_i.req_type;
            pos_q   <= (req_i.percent_hundredths > FULL_POS) ?
                       FULL_POS : req_i.percent_hundredths;
            bpm_q   <= req_i.bpm;
            dt_q    <= req_i.dt_ms;
            sel_q   <= req_i.bucket_sel;
            w_q     <= W_W'(req_i.bpm) * W_W'(req_i.dt_ms);
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          priority if (req_q == REQ_CLEAR) begin
            valid_q    <= '0;
            tot_wsum_q <= '0;
            tot_dur_q  <= '0;
            cov_q      <= '0;
            end_q      <= '0;
            peak_q     <= '0;
            peak_at_q  <= '0;
            acc_q      <= 1'b1;
            idx_q      <= '0;
            bavg_q     <= '0;
            tavg_q     <= '0;
            state_q    <= S_OUT;
          end else if (req_q == REQ_READ) begin
            bin_q   <= sel_bin;
            acc_q   <= 1'b1;
            idx_q   <= IDX_W'(sel_bin);
            state_q <= S_FETCH;
          end else if (rec_ok) begin
            x_q     <= X_W'(pos_q) * X_W'(BUCKETS);
            acc_q   <= 1'b1;
            state_q <= S_EST;
          end else begin
            // ignored sample or unknown request
            acc_q   <= 1'b0;
            idx_q   <= '0;
            bavg_q  <= '0;
            state_q <= S_TDIV;
          end
        end
        S_EST: begin
          qest_q  <= est_prod[RECIP_SH +: Q_W];
          state_q <= S_FIX;
        end
        S_FIX: begin
          bin_q   <= bin_fix;
          idx_q   <= IDX_W'(bin_fix);
          state_q <= S_FETCH;
        end
        // read data is here: update a record bin or keep a read bin
        S_FETCH: begin
          if (req_q == REQ_RECORD) begin
            valid_q[bin_q] <= 1'b1;
            ent_q          <= new_ent;
            tot_wsum_q     <= tsum_add[TOT_WSUM_W] ? '1 : tsum_add[TOT_WSUM_W-1:0];
            tot_dur_q      <= tdur_add[TOT_DUR_W] ? '1 : tdur_add[TOT_DUR_W-1:0];
            if ((cur_ent.dur == '0) && (cov_q != '1)) begin
              cov_q <= cov_q + 1'b1;
            end
            end_q <= pos_q;
            if (bpm_q > peak_q) begin
              peak_q    <= bpm_q;
              peak_at_q <= pos_q;
            end
          end else begin
            ent_q <= cur_ent;
          end
          state_q <= S_BDIV;
        end
        S_BDIV: begin
          state_q <= S_BWAIT;
        end
        S_BWAIT: begin
          if (div_rsp.done) begin
            bavg_q  <= div_rsp.quot;
            state_q <= S_TDIV;
          end
        end
        S_TDIV: begin
          state_q <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_rsp.done) begin
            tavg_q  <= div_rsp.quot;
            state_q <= S_OUT;
          end
        end
        // hand over once the output register is free
        S_OUT: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_acc_q     <= acc_q;
            out_idx_q     <= idx_q;
            out_bavg_q    <= bavg_q;
            out_tavg_q    <= tavg_q;
            out_cov_q     <= cov_q;
            out_peak_q    <= peak_q;
            out_peak_at_q <= peak_at_q;
            out_end_q     <= end_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.accepted        = out_acc_q;
  assign rsp_o.bucket_index    = out_idx_q;
  assign rsp_o.bucket_average  = out_bavg_q;
  assign rsp_o.overall_average = out_tavg_q;
  assign rsp_o.covered_buckets = out_cov_q;
  assign rsp_o.peak_rate       = out_peak_q;
  assign rsp_o.peak_position   = out_peak_at_q;
  assign rsp_o.last_position   = out_end_q;

endmodule

`default_nettype wire

### rtl/twbh_checker.sv
// ----------------------------------------------------------------------------
// twbh_checker
// Port-level checks of the histogram result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module twbh_checker import twbh_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             ready_i,
  input logic             accepted_i,
  input logic [IDX_W-1:0] bucket_index_i,
  input logic [AVG_W-1:0] bucket_average_i,
  input logic [AVG_W-1:0] overall_average_i,
  input logic [CNT_W-1:0] covered_buckets_i,
  input logic [BPM_W-1:0] peak_rate_i,
  input logic [POS_W-1:0] peak_position_i,
  input logic [POS_W-1:0] last_position_i
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(accepted_i) &&
      $stable(bucket_index_i) && $stable(bucket_average_i) &&
      $stable(overall_average_i) && $stable(covered_buckets_i) &&
      $stable(peak_rate_i) && $stable(peak_position_i) &&
      $stable(last_position_i))
    else $error("result beat changed while stalled");

  // ignored samples report no bin
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !accepted_i |-> bucket_index_i == '0 && bucket_average_i == '0)
    else $error("ignored sample reports a bin");

  // averages stay within the rate limit
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> bucket_average_i <= AVG_MAX && overall_average_i <= AVG_MAX)
    else $error("average beyond limit");

  // no peak means no peak position
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && peak_rate_i == '0 |-> peak_position_i == '0)
    else $error("peak position without peak");

  // no covered bin means no time and no overall average
  a_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && covered_buckets_i == '0 |-> overall_average_i == '0)
    else $error("overall average with nothing covered");

endmodule

bind time_weighted_bucket_histogram_unit twbh_checker u_twbh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (rsp_o.valid),
  .ready_i          (rsp_o.ready),
  .accepted_i       (rsp_o.accepted),
  .bucket_index_i   (rsp_o.bucket_index),
  .bucket_average_i (rsp_o.bucket_average),
  .overall_average_i(rsp_o.overall_average),
  .covered_buckets_i(rsp_o.covered_buckets),
  .peak_rate_i      (rsp_o.peak_rate),
  .peak_position_i  (rsp_o.peak_position),
  .last_position_i  (rsp_o.last_position)
);

`default_nettype wire

### tb/sv/time_weighted_bucket_histogram_unit_tb.sv
// ----------------------------------------------------------------------------
// time_weighted_bucket_histogram_unit_tb
// Self-checking bench for the time weighted bucket histogram. Requests go in
// on the request channel. A behavioral histogram inside the bench tracks the
// per-bin and total sums and queues the expected result for each accepted
// beat. Each result beat is compared field by field with the oldest entry.
// Directed cases cover the bin edges, clamping, ignored samples, reads and
// clear. Random traffic follows, with random idling on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module time_weighted_bucket_histogram_unit_tb;
  import twbh_pkg::*;

  // request code that the block treats like an ignored sample
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned     STALL_MAX    = 4;
  localparam int unsigned     HOLD_CYCLES  = 400;
  localparam int unsigned     HOLD_ITEMS   = 40;
  localparam int unsigned     PHASE_ITEMS  = 320;
  localparam int unsigned     DRAIN_CYCLES = 150;
  localparam longint unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] percent_hundredths;
    logic [BPM_W-1:0] bpm;
    logic [DT_W-1:0]  dt_ms;
    logic [SEL_W-1:0] bucket_sel;
  } hist_req_t;

  typedef struct packed {
    logic             accepted;
    logic [IDX_W-1:0] bucket_index;
    logic [AVG_W-1:0] bucket_average;
    logic [AVG_W-1:0] overall_average;
    logic [CNT_W-1:0] covered_buckets;
    logic [BPM_W-1:0] peak_rate;
    logic [POS_W-1:0] peak_position;
    logic [POS_W-1:0] last_position;
  } hist_result_t;

  logic clk_i;
  logic rst_ni;

  twbh_req_if req_bus ();
  twbh_rsp_if rsp_bus ();

  time_weighted_bucket_histogram_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // expected histogram contents
  bit [BIN_WSUM_W-1:0] bin_rate_time [BUCKETS];
  bit [BIN_DUR_W-1:0]  bin_time [BUCKETS];
  bit [TOT_WSUM_W-1:0] total_rate_time;
  bit [TOT_DUR_W-1:0]  total_time;
  bit [CNT_W-1:0]      bins_covered;
  bit [POS_W-1:0]      last_pos;
  bit [BPM_W-1:0]      peak_bpm;
  bit [POS_W-1:0]      peak_pos;

  hist_result_t    pending_results [$];
  int unsigned     mismatch_count;
  int unsigned     results_seen;
  longint unsigned cycle_count;

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req  = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // histogram prediction
  // ---------------------------------------------------------------------------

  function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b,
                                            int unsigned width);
    bit [63:0] ceiling;
    bit [63:0] s;
    ceiling = (64'd1 << width) - 64'd1;
    s = a + b;
    return (s > ceiling) ? ceiling : s;
  endfunction

  // floor(sum * 256 / dur), zero for no time, capped at the largest rate
  function automatic logic [AVG_W-1:0] mean_rate_q8(bit [63:0] sum, bit [63:0] dur);
    bit [63:0] q;
    if (dur == 0) return '0;
    q = (sum << AVG_FRAC) / dur;
    return (q > AVG_MAX) ? AVG_MAX : AVG_W'(q);
  endfunction

  function automatic void clear_histogram();
    foreach (bin_rate_time[i]) begin
      bin_rate_time[i] = '0;
      bin_time[i]      = '0;
    end
    total_rate_time = '0;
    total_time      = '0;
    bins_covered    = '0;
    last_pos        = '0;
    peak_bpm        = '0;
    peak_pos        = '0;
  endfunction

  function automatic hist_result_t update_histogram(hist_req_t it);
    hist_result_t r;
    int unsigned  pos;
    int unsigned  bin;
    bit [W_W-1:0] w;
    r = '0;
    if (it.req_type == REQ_CLEAR) begin
      clear_histogram();
      r.accepted = 1'b1;
    end else begin
      if (it.req_type == REQ_READ) begin
        bin = (it.bucket_sel >= BUCKETS) ? BUCKETS - 1 : 32'(it.bucket_sel);
        r.accepted       = 1'b1;
        r.bucket_index   = IDX_W'(bin);
        r.bucket_average = mean_rate_q8(64'(bin_rate_time[bin]), 64'(bin_time[bin]));
      end else if (it.req_type == REQ_RECORD && it.bpm != 0 && it.dt_ms != 0) begin
        pos = (it.percent_hundredths > FULL_POS) ? 32'(FULL_POS)
                                                 : 32'(it.percent_hundredths);
        bin = pos * BUCKETS / 32'(FULL_POS);
        if (bin > BUCKETS - 1) bin = BUCKETS - 1;
        // first time in this bin
        if (bin_time[bin] == 0 && bins_covered != '1) bins_covered++;
        w = W_W'(it.bpm) * W_W'(it.dt_ms);
        bin_rate_time[bin] = BIN_WSUM_W'(add_clamped(64'(bin_rate_time[bin]), 64'(w),
                                                     BIN_WSUM_W));
        bin_time[bin]      = BIN_DUR_W'(add_clamped(64'(bin_time[bin]), 64'(it.dt_ms),
                                                    BIN_DUR_W));
        total_rate_time    = TOT_WSUM_W'(add_clamped(64'(total_rate_time), 64'(w),
                                                     TOT_WSUM_W));
        total_time         = TOT_DUR_W'(add_clamped(64'(total_time), 64'(it.dt_ms),
                                                    TOT_DUR_W));
        last_pos = POS_W'(pos);
        // strictly greater keeps the first position of the peak
        if (it.bpm > peak_bpm) begin
          peak_bpm = it.bpm;
          peak_pos = POS_W'(pos);
        end
        r.accepted       = 1'b1;
        r.bucket_index   = IDX_W'(bin);
        r.bucket_average = mean_rate_q8(64'(bin_rate_time[bin]), 64'(bin_time[bin]));
      end
      r.overall_average = mean_rate_q8(64'(total_rate_time), 64'(total_time));
      r.covered_buckets = bins_covered;
      r.peak_rate       = peak_bpm;
      r.peak_position   = peak_pos;
      r.last_position   = last_pos;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_result();
    hist_result_t got;
    hist_result_t want;
    got.accepted        = rsp_bus.accepted;
    got.bucket_index    = rsp_bus.bucket_index;
    got.bucket_average  = rsp_bus.bucket_average;
    got.overall_average = rsp_bus.overall_average;
    got.covered_buckets = rsp_bus.covered_buckets;
    got.peak_rate       = rsp_bus.peak_rate;
    got.peak_position   = rsp_bus.peak_position;
    got.last_position   = rsp_bus.last_position;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with no request outstanding");
    end else begin
      want = pending_results.pop_front();
      compare_field("accepted", 64'(got.accepted), 64'(want.accepted));
      compare_field("bucket_index", 64'(got.bucket_index), 64'(want.bucket_index));
      compare_field("bucket_average", 64'(got.bucket_average),
                    64'(want.bucket_average));
      compare_field("overall_average", 64'(got.overall_average),
                    64'(want.overall_average));
      compare_field("covered_buckets", 64'(got.covered_buckets),
                    64'(want.covered_buckets));
      compare_field("peak_rate", 64'(got.peak_rate), 64'(want.peak_rate));
      compare_field("peak_position", 64'(got.peak_position), 64'(want.peak_position));
      compare_field("last_position", 64'(got.last_position), 64'(want.last_position));
    end
  endtask

  // result side: random ready gaps, one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_bus.valid !== 1'b1);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic hist_req_t make_req(logic [REQ_W-1:0] kind, int unsigned pos,
                                         int unsigned bpm, int unsigned dt,
                                         int unsigned sel);
    hist_req_t it;
    it.req_type           = kind;
    it.percent_hundredths = POS_W'(pos);
    it.bpm                = BPM_W'(bpm);
    it.dt_ms              = DT_W'(dt);
    it.bucket_sel         = SEL_W'(sel);
    return it;
  endfunction

  // mostly well-formed samples and reads, some noise
  function automatic hist_req_t random_request();
    hist_req_t   it;
    int unsigned roll;
    it.req_type           = REQ_RECORD;
    it.percent_hundredths = POS_W'($urandom);
    it.bpm                = BPM_W'($urandom);
    it.dt_ms              = DT_W'($urandom);
    it.bucket_sel         = SEL_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      if ($urandom_range(0, 9) != 0)
        it.percent_hundredths = POS_W'($urandom_range(0, FULL_POS));
      it.bpm = BPM_W'($urandom_range(1, RATE_MAX));
      it.dt_ms = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(1, 65535))
                                              : DT_W'($urandom_range(1, 2000));
    end else if (roll < 80) begin
      it.req_type = REQ_READ;
    end else if (roll < 87) begin
      if ($urandom_range(0, 1) == 0) it.bpm = '0;
      else it.dt_ms = '0;
    end else if (roll < 90) begin
      it.req_type = REQ_UNUSED;
    end else if (roll < 91) begin
      it.req_type = REQ_CLEAR;
    end
    return it;
  endfunction

  // one request beat, prediction taken at acceptance
  task automatic send_request(input hist_req_t it);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid              <= 1'b1;
    req_bus.req_type           <= it.req_type;
    req_bus.percent_hundredths <= it.percent_hundredths;
    req_bus.bpm                <= it.bpm;
    req_bus.dt_ms              <= it.dt_ms;
    req_bus.bucket_sel         <= it.bucket_sel;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    pending_results.push_back(update_histogram(it));
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // bin edges, clamping and peak tracking
  task automatic test_record_bins();
    send_request(make_req(REQ_RECORD, 0, 1, 1, 0));
    send_request(make_req(REQ_RECORD, 78, 200, 500, 0));
    send_request(make_req(REQ_RECORD, 79, 100, 65535, 0));
    send_request(make_req(REQ_RECORD, 9999, RATE_MAX, 65535, 0));
    // equal rate does not move the peak
    send_request(make_req(REQ_RECORD, FULL_POS, RATE_MAX, 1000, 0));
    // position above full scale
    send_request(make_req(REQ_RECORD, 16383, 400, 65535, 127));
    send_request(make_req(REQ_RECORD, 5000, 1, 1, 0));
  endtask

  // zero rate, zero duration and the unused code leave the state alone
  task automatic test_ignored_requests();
    send_request(make_req(REQ_RECORD, 123, 0, 100, 5));
    send_request(make_req(REQ_RECORD, 5000, 50, 0, 9));
    send_request(make_req(REQ_UNUSED, 16383, RATE_MAX, 65535, 127));
    send_request(make_req(REQ_RECORD, 0, 0, 0, 0));
  endtask

  // written bins
  task automatic test_bucket_reads();
    send_request(make_req(REQ_READ, 0, 0, 0, 0));
    send_request(make_req(REQ_READ, 16383, RATE_MAX, 65535, 1));
    send_request(make_req(REQ_READ, 0, 0, 0, 127));
    send_request(make_req(REQ_READ, 0, 0, 0, 64));
    send_request(make_req(REQ_READ, 10000, 7, 3, 0));
  endtask

  // clear zeroes everything, then the store refills
  task automatic test_clear();
    send_request(make_req(REQ_CLEAR, 16383, RATE_MAX, 65535, 127));
    send_request(make_req(REQ_READ, 0, 0, 0, 127));
    send_request(make_req(REQ_RECORD, 3000, 20, 10, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 38));
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit src_gaps,
                                     input bit dst_gaps);
    send_idle = src_gaps;
    recv_idle = dst_gaps;
    repeat (count) send_request(random_request());
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req  = 1'b1;
    repeat (HOLD_ITEMS) send_request(random_request());
    recv_idle = 1'b1;
  endtask

  initial begin : stimulus
    mismatch_count = 0;
    results_seen   = 0;
    rst_ni                     <= 1'b0;
    req_bus.valid              <= 1'b0;
    req_bus.req_type           <= REQ_RECORD;
    req_bus.percent_hundredths <= '0;
    req_bus.bpm                <= '0;
    req_bus.dt_ms              <= '0;
    req_bus.bucket_sel         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_record_bins();
    test_ignored_requests();
    test_bucket_reads();
    test_clear();
    test_random_traffic(PHASE_ITEMS, 1'b1, 1'b1);
    test_random_traffic(PHASE_ITEMS, 1'b0, 1'b0);
    test_backpressure();
    test_random_traffic(PHASE_ITEMS, 1'b1, 1'b0);
    test_random_traffic(PHASE_ITEMS, 1'b0, 1'b1);
    drain_results();

    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
